### src/subsystem_health_supervisor_top_macros.svh
// Assertion helpers for the supervisor top level.
`ifndef SUBSYSTEM_HEALTH_SUPERVISOR_TOP_MACROS_SVH
`define SUBSYSTEM_HEALTH_SUPERVISOR_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SHS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("supervisor check failed");

// Next-cycle implication, checked outside reset.
`define SHS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error("supervisor check failed");

`endif

### src/shs_pkg.sv
package shs_pkg;

    localparam int IDX_W       = 4;
    localparam int NUM_IDX     = 1 << IDX_W;
    localparam int AGE_W       = 16;
    localparam int MASK_W      = 16;
    localparam int STATE_W     = 3;
    localparam int MAX_SUBSYSTEMS_DEF = 16;
    localparam logic [AGE_W-1:0] TIMEOUT_RST = 16'd5;
    localparam logic [AGE_W-1:0] AGE_MAX     = '1;

    typedef enum logic [1:0] {
        K_REGISTER  = 2'd0,
        K_HEARTBEAT = 2'd1,
        K_FAULT     = 2'd2,
        K_TICK      = 2'd3
    } t_kind;

    localparam logic [STATE_W-1:0] ST_INIT     = 3'd0;
    localparam logic [STATE_W-1:0] ST_NOMINAL  = 3'd1;
    localparam logic [STATE_W-1:0] ST_DEGRADED = 3'd2;
    localparam logic [STATE_W-1:0] ST_RECOVERY = 3'd3;
    localparam logic [STATE_W-1:0] ST_SAFE     = 3'd4;

    typedef struct packed {
        logic [1:0]       kind;
        logic [IDX_W-1:0] subsystem_index;
        logic             beat_active;
        logic             healthy_flag;
        logic             emergency;
    } t_in_req;

    typedef struct packed {
        logic [STATE_W-1:0] sup_state;
        logic               state_published;
        logic [MASK_W-1:0]  degraded_mask;
    } t_out_rsp;

    // Command broadcast to every cell on an accepted request.
    typedef struct packed {
        logic             valid;
        t_kind            kind;
        logic [IDX_W-1:0] index;
        logic             active;
        logic             healthy;
    } t_cell_cmd;

    // Summary handed from cell to cell along the row.
    typedef struct packed {
        logic any_reg;
        logic all_ok;
        logic hit;
    } t_chain;

endpackage

### src/shs_cell.sv
module shs_cell #(
    parameter int CELL_ID = 0
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  shs_pkg::t_cell_cmd           i_cmd,
    input  logic [shs_pkg::AGE_W-1:0]    i_timeout,
    input  shs_pkg::t_chain              i_chain,
    output shs_pkg::t_chain              o_chain,
    output logic                         o_degraded
);

    logic                      r_registered;
    logic                      r_active;
    logic                      r_healthy;
    logic [shs_pkg::AGE_W-1:0] r_age;
    logic                      sel;

    assign sel = (CELL_ID < shs_pkg::NUM_IDX)
              && (i_cmd.index == shs_pkg::IDX_W'(CELL_ID));

    assign o_degraded = r_registered && (!r_active || !r_healthy || (r_age > i_timeout));

    assign o_chain.any_reg = i_chain.any_reg | r_registered;
    assign o_chain.all_ok  = i_chain.all_ok & !o_degraded;
    assign o_chain.hit     = i_chain.hit | (sel & r_registered);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_registered <= 1'b0;
            r_active     <= 1'b0;
            r_healthy    <= 1'b0;
            r_age        <= '0;
        end else if (i_cmd.valid) begin
            unique case (i_cmd.kind)
                shs_pkg::K_REGISTER: begin
                    if (sel) begin
                        r_registered <= 1'b1;
                        r_active     <= 1'b0;
                        r_healthy    <= 1'b0;
                        r_age        <= '0;
                    end
                end
                shs_pkg::K_HEARTBEAT: begin
                    if (sel && r_registered) begin
                        r_active  <= i_cmd.active;
                        r_healthy <= i_cmd.healthy;
                        r_age     <= '0;
                    end
                end
                shs_pkg::K_TICK: begin
                    // saturate at the top of the range
                    if (r_registered && (r_age != shs_pkg::AGE_MAX)) begin
                        r_age <= r_age + shs_pkg::AGE_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

### src/subsystem_health_supervisor_top.sv
// Subsystem health supervisor.
// Input channel (i_in_valid / o_in_ready / i_in): one request per item, one of
// register, heartbeat, fault event or evaluation tick, with a subsystem index
// and the heartbeat and fault flags. Output channel (o_out_valid / i_out_ready
// / o_out): exactly one response per request, carrying the system state, a
// publish flag and a mask of degraded registered subsystems.
// Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data): the timeout in
// ticks; always ready, write only while no request is in flight.
// Each subsystem lives in one cell of a row; the cells update at the edge that
// accepts a request, and the row summary (any registered, all healthy, target
// registered) ripples cell to cell. The next edge evaluates the system state
// and loads the response register. No new request is accepted while one is
// being evaluated.
// A new request is accepted while a response waits, provided it is taken in
// that same cycle; a stalled receiver holds the response and blocks input.
// Reset (synchronous, active low) clears all cells, sets the state to INIT and
// the timeout to 5 ticks. An emergency fault latches SAFE until reset.
`include "subsystem_health_supervisor_top_macros.svh"

module subsystem_health_supervisor_top #(
    parameter int MAX_SUBSYSTEMS = shs_pkg::MAX_SUBSYSTEMS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  shs_pkg::t_in_req            i_in,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output shs_pkg::t_out_rsp           o_out,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [shs_pkg::AGE_W-1:0]   i_cfg_data
);

    typedef enum logic {
        S_IDLE,
        S_EVAL
    } t_state;

    t_state                          r_state;
    logic [shs_pkg::STATE_W-1:0]     r_sys_state;
    logic                            r_out_valid;
    shs_pkg::t_out_rsp               r_out;
    logic                            r_emerg;
    logic                            r_do_eval;
    logic [shs_pkg::AGE_W-1:0]       r_timeout;

    logic                            in_acc;
    logic                            idx_ok;
    logic                            do_eval;
    shs_pkg::t_cell_cmd              cmd;
    shs_pkg::t_chain                 chain [MAX_SUBSYSTEMS+1];
    logic [MAX_SUBSYSTEMS-1:0]       deg;
    logic [shs_pkg::MASK_W-1:0]      mask;
    logic [shs_pkg::STATE_W-1:0]     n_sys_state;
    logic                            n_pub;
    logic [shs_pkg::STATE_W-1:0]     eval_state;

    // Accept only in IDLE and when the response register is free by the next edge.
    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign cmd.valid   = in_acc;
    assign cmd.kind    = shs_pkg::t_kind'(i_in.kind);
    assign cmd.index   = i_in.subsystem_index;
    assign cmd.active  = i_in.beat_active;
    assign cmd.healthy = i_in.healthy_flag;

    assign chain[0] = '{any_reg: 1'b0, all_ok: 1'b1, hit: 1'b0};

    for (genvar g = 0; g < MAX_SUBSYSTEMS; g++) begin : g_cell
        shs_cell #(
            .CELL_ID(g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (cmd),
            .i_timeout  (r_timeout),
            .i_chain    (chain[g]),
            .o_chain    (chain[g+1]),
            .o_degraded (deg[g])
        );
    end

    // Only the first sixteen entries show in the mask.
    for (genvar b = 0; b < shs_pkg::MASK_W; b++) begin : g_mask
        if (b < MAX_SUBSYSTEMS) begin : g_live
            assign mask[b] = deg[b];
        end else begin : g_zero
            assign mask[b] = 1'b0;
        end
    end

    assign idx_ok = 32'(i_in.subsystem_index) < 32'(MAX_SUBSYSTEMS);

    // Decide at accept whether the item triggers an evaluation.
    always_comb begin
        unique case (shs_pkg::t_kind'(i_in.kind))
            shs_pkg::K_REGISTER:  do_eval = idx_ok;
            shs_pkg::K_HEARTBEAT: do_eval = chain[MAX_SUBSYSTEMS].hit;
            shs_pkg::K_FAULT:     do_eval = !i_in.emergency;
            default:              do_eval = 1'b1;
        endcase
    end

    always_comb begin
        if (!chain[MAX_SUBSYSTEMS].any_reg) begin
            eval_state = shs_pkg::ST_INIT;
        end else if (chain[MAX_SUBSYSTEMS].all_ok) begin
            eval_state = shs_pkg::ST_NOMINAL;
        end else begin
            eval_state = shs_pkg::ST_DEGRADED;
        end
    end

    // Emergency wins and always reports; SAFE otherwise holds; else report only on a change.
    always_comb begin
        n_sys_state = r_sys_state;
        n_pub       = 1'b0;
        priority if (r_emerg) begin
            n_sys_state = shs_pkg::ST_SAFE;
            n_pub       = 1'b1;
        end else if (r_do_eval && (r_sys_state != shs_pkg::ST_SAFE)) begin
            n_sys_state = eval_state;
            n_pub       = (eval_state != r_sys_state);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= shs_pkg::TIMEOUT_RST;
        end else if (i_cfg_valid) begin
            r_timeout <= i_cfg_data;
        end
    end

    // Response payload: load on evaluation, hold while waiting.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sys_state <= shs_pkg::ST_INIT;
            r_out_valid <= 1'b0;
            r_out       <= '0;
            r_emerg     <= 1'b0;
            r_do_eval   <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_emerg   <= (shs_pkg::t_kind'(i_in.kind) == shs_pkg::K_FAULT)
                                  && i_in.emergency;
                        r_do_eval <= do_eval;
                        r_state   <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_sys_state           <= n_sys_state;
                    r_out_valid           <= 1'b1;
                    r_out.sup_state       <= n_sys_state;
                    r_out.state_published <= n_pub;
                    r_out.degraded_mask   <= mask;
                    r_state               <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `SHS_ASSERT_NEXT(a_accept_to_eval, i_clk, i_rst_n, in_acc, (r_state == S_EVAL))
    `SHS_ASSERT_NOW(a_no_accept_in_eval, i_clk, i_rst_n, (r_state == S_EVAL), !o_in_ready)
    `SHS_ASSERT_NEXT(a_safe_sticks, i_clk, i_rst_n, (r_sys_state == shs_pkg::ST_SAFE),
        (r_sys_state == shs_pkg::ST_SAFE))
    `SHS_ASSERT_NEXT(a_emerg_reports, i_clk, i_rst_n,
        (in_acc && (i_in.kind == shs_pkg::K_FAULT) && i_in.emergency),
        ##1 (o_out_valid && o_out.state_published && (o_out.sup_state == shs_pkg::ST_SAFE)))
    `SHS_ASSERT_NOW(a_no_recovery, i_clk, i_rst_n, o_out_valid,
        (o_out.sup_state != shs_pkg::ST_RECOVERY))

endmodule

### bench/tb_subsystem_health_supervisor_top.sv
`timescale 1ns / 1ps

module tb_subsystem_health_supervisor_top;

    localparam int N_SUB = shs_pkg::MAX_SUBSYSTEMS_DEF;

    // Clock, reset and block inputs, all known from time zero.
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    shs_pkg::t_in_req i_in = '0;
    logic i_out_ready = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [shs_pkg::AGE_W-1:0] i_cfg_data = '0;
    logic o_in_ready;
    logic o_out_valid;
    shs_pkg::t_out_rsp o_out;
    logic o_cfg_ready;

    subsystem_health_supervisor_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the subsystem table, the state and the timeout.
    logic reg_tab [N_SUB];
    logic act_tab [N_SUB];
    logic hl_tab [N_SUB];
    logic [shs_pkg::AGE_W-1:0] age_tab [N_SUB];
    logic [shs_pkg::STATE_W-1:0] sys_state;
    logic [shs_pkg::AGE_W-1:0] timeout_cur;

    shs_pkg::t_in_req request_q [$];   // requests waiting to be offered
    shs_pkg::t_out_rsp report_q [$];   // predicted state reports, oldest first

    int send_idle_pct = 21;
    int recv_idle_pct = 82;
    int hold_req = 0;
    int hold_left = 0;
    bit in_taken = 1'b0;
    int err_count = 0;
    int n_checked = 0;
    int n_published = 0;
    int state_seen [5] = '{default: 0};

    function automatic logic entry_bad(input int i);
        return !act_tab[i] || !hl_tab[i] || (age_tab[i] > timeout_cur);
    endfunction

    function automatic logic [shs_pkg::MASK_W-1:0] degraded_bits();
        logic [shs_pkg::MASK_W-1:0] m;
        m = '0;
        for (int i = 0; i < N_SUB && i < shs_pkg::MASK_W; i++) begin
            if (reg_tab[i] && entry_bad(i)) m[i] = 1'b1;
        end
        return m;
    endfunction

    // Recompute the system state; returns 1 when it changed.
    function automatic logic evaluate_state();
        logic any_reg;
        logic all_ok;
        logic [shs_pkg::STATE_W-1:0] nxt;
        if (sys_state == shs_pkg::ST_SAFE) return 1'b0;
        any_reg = 1'b0;
        all_ok = 1'b1;
        for (int i = 0; i < N_SUB; i++) begin
            if (reg_tab[i]) begin
                any_reg = 1'b1;
                if (entry_bad(i)) all_ok = 1'b0;
            end
        end
        nxt = !any_reg ? shs_pkg::ST_INIT
                       : (all_ok ? shs_pkg::ST_NOMINAL : shs_pkg::ST_DEGRADED);
        if (nxt != sys_state) begin
            sys_state = nxt;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Apply one request to the shadow table and build the report it causes.
    function automatic shs_pkg::t_out_rsp supervise(input shs_pkg::t_in_req rq);
        shs_pkg::t_out_rsp rsp;
        logic pub;
        int idx;
        pub = 1'b0;
        idx = int'(rq.subsystem_index);
        case (shs_pkg::t_kind'(rq.kind))
            shs_pkg::K_REGISTER: begin
                reg_tab[idx] = 1'b1;
                act_tab[idx] = 1'b0;
                hl_tab[idx] = 1'b0;
                age_tab[idx] = '0;
                pub = evaluate_state();
            end
            shs_pkg::K_HEARTBEAT: begin
                if (reg_tab[idx]) begin
                    act_tab[idx] = rq.beat_active;
                    hl_tab[idx] = rq.healthy_flag;
                    age_tab[idx] = '0;
                    pub = evaluate_state();
                end
            end
            shs_pkg::K_FAULT: begin
                if (rq.emergency) begin
                    sys_state = shs_pkg::ST_SAFE;
                    pub = 1'b1;
                end else begin
                    pub = evaluate_state();
                end
            end
            shs_pkg::K_TICK: begin
                for (int i = 0; i < N_SUB; i++) begin
                    if (reg_tab[i] && age_tab[i] != shs_pkg::AGE_MAX)
                        age_tab[i] = age_tab[i] + shs_pkg::AGE_W'(1);
                end
                pub = evaluate_state();
            end
            default: ;
        endcase
        rsp.sup_state = sys_state;
        rsp.state_published = pub;
        rsp.degraded_mask = degraded_bits();
        return rsp;
    endfunction

    function automatic shs_pkg::t_in_req mk_req(input shs_pkg::t_kind k, input int idx,
                                                input logic act, input logic hl,
                                                input logic em);
        shs_pkg::t_in_req rq;
        rq.kind = k;
        rq.subsystem_index = 4'(idx);
        rq.beat_active = act;
        rq.healthy_flag = hl;
        rq.emergency = em;
        return rq;
    endfunction

    // Random request over entries 0..span; flags outside the kind stay random.
    function automatic shs_pkg::t_in_req rand_req(input int span, input bit allow_emerg);
        shs_pkg::t_in_req rq;
        int pick;
        pick = $urandom_range(99);
        rq.subsystem_index = 4'($urandom_range(span));
        rq.beat_active = 1'($urandom_range(1));
        rq.healthy_flag = 1'($urandom_range(1));
        rq.emergency = 1'($urandom_range(1));
        if (pick < 12) begin
            rq.kind = shs_pkg::K_REGISTER;
        end else if (pick < 57) begin
            rq.kind = shs_pkg::K_HEARTBEAT;
            if ($urandom_range(99) < 80) begin
                rq.beat_active = 1'b1;
                rq.healthy_flag = 1'b1;
            end
        end else if (pick < 67) begin
            rq.kind = shs_pkg::K_FAULT;
            rq.emergency = allow_emerg && ($urandom_range(7) == 0);
        end else begin
            rq.kind = shs_pkg::K_TICK;
        end
        return rq;
    endfunction

    // Append one request to the pending list.
    task automatic queue_req(input shs_pkg::t_in_req rq);
        request_q = {request_q, rq};
    endtask

    task automatic queue_random(input int n, input int span, input bit allow_emerg);
        for (int k = 0; k < n; k++) queue_req(rand_req(span, allow_emerg));
    endtask

    // Hold until every queued request was taken and every report came back.
    task automatic wait_drained();
        do @(posedge i_clk); while (request_q.size() != 0 || i_in_valid || report_q.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_timeout(input logic [shs_pkg::AGE_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        timeout_cur = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Driver, accept side: predict the report of each request the block takes.
    always @(posedge i_clk) begin
        in_taken = 1'b0;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            in_taken = 1'b1;
            report_q = {report_q, supervise(i_in)};
        end
    end

    // Driver, launch side: hold the payload until taken, then offer the next
    // request unless this cycle idles.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in <= request_q.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off counted here on request.
    always @(negedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: compare each delivered report with the oldest prediction.
    always @(posedge i_clk) begin
        shs_pkg::t_out_rsp want;
        shs_pkg::t_out_rsp got;
        bit bad;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = o_out;
            if (report_q.size() == 0) begin
                err_count++;
                $display("%0t: report expected none actual %h", $time, got);
            end else begin
                want = report_q.pop_front();
                n_checked++;
                if (got.state_published) n_published++;
                if (got.sup_state <= shs_pkg::ST_SAFE) state_seen[got.sup_state]++;
                bad = 1'b0;
                if (got.sup_state != want.sup_state) begin
                    bad = 1'b1;
                    $display("%0t: sup_state expected %0d actual %0d",
                             $time, want.sup_state, got.sup_state);
                end
                if (got.state_published != want.state_published) begin
                    bad = 1'b1;
                    $display("%0t: state_published expected %0b actual %0b",
                             $time, want.state_published, got.state_published);
                end
                if (got.degraded_mask != want.degraded_mask) begin
                    bad = 1'b1;
                    $display("%0t: degraded_mask expected %h actual %h",
                             $time, want.degraded_mask, got.degraded_mask);
                end
                if (bad) err_count++;
            end
        end
    end

    // Watchdog far beyond the slowest correct run.
    initial begin
        #20_000_000;
        $display("subsystem_health_supervisor_top test failed");
        $finish;
    end

    initial begin
        for (int i = 0; i < N_SUB; i++) begin
            reg_tab[i] = 1'b0;
            act_tab[i] = 1'b0;
            hl_tab[i] = 1'b0;
            age_tab[i] = '0;
        end
        sys_state = shs_pkg::ST_INIT;
        timeout_cur = shs_pkg::TIMEOUT_RST;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty table, heartbeat to an unregistered entry, ignored
        // flags, register / heartbeat flag combinations, timeout past the
        // reset value of 5, re-registration, all index bits both ways.
        queue_req(mk_req(shs_pkg::K_TICK, 0, 1'b0, 1'b0, 1'b0));
        queue_req(mk_req(shs_pkg::K_HEARTBEAT, 0, 1'b1, 1'b1, 1'b0));
        queue_req(mk_req(shs_pkg::K_FAULT, 15, 1'b1, 1'b1, 1'b0));
        queue_req(mk_req(shs_pkg::K_REGISTER, 0, 1'b0, 1'b0, 1'b0));
        queue_req(mk_req(shs_pkg::K_HEARTBEAT, 0, 1'b1, 1'b1, 1'b0));
        queue_req(mk_req(shs_pkg::K_REGISTER, 15, 1'b1, 1'b1, 1'b1));
        queue_req(mk_req(shs_pkg::K_HEARTBEAT, 15, 1'b0, 1'b1, 1'b1));
        queue_req(mk_req(shs_pkg::K_HEARTBEAT, 15, 1'b1, 1'b0, 1'b0));
        queue_req(mk_req(shs_pkg::K_HEARTBEAT, 15, 1'b1, 1'b1, 1'b0));
        for (int k = 0; k < 6; k++)
            queue_req(mk_req(shs_pkg::K_TICK, 15, 1'b1, 1'b1, 1'b1));
        queue_req(mk_req(shs_pkg::K_HEARTBEAT, 0, 1'b1, 1'b1, 1'b0));
        queue_req(mk_req(shs_pkg::K_HEARTBEAT, 15, 1'b1, 1'b1, 1'b0));
        queue_req(mk_req(shs_pkg::K_REGISTER, 15, 1'b0, 1'b0, 1'b0));
        queue_req(mk_req(shs_pkg::K_HEARTBEAT, 10, 1'b1, 1'b1, 1'b0));
        queue_req(mk_req(shs_pkg::K_REGISTER, 5, 1'b0, 1'b0, 1'b0));
        queue_req(mk_req(shs_pkg::K_HEARTBEAT, 5, 1'b1, 1'b1, 1'b0));
        queue_req(mk_req(shs_pkg::K_HEARTBEAT, 15, 1'b1, 1'b1, 1'b0));
        queue_req(mk_req(shs_pkg::K_FAULT, 0, 1'b0, 1'b0, 1'b0));
        wait_drained();

        // Sender mostly busy, receiver mostly stalled; short timeout, few
        // entries so NOMINAL is reachable. A long hold-off backs the block up.
        write_timeout(16'd1);
        queue_random(620, 3, 1'b0);
        do @(posedge i_clk); while (request_q.size() > 400);
        hold_req = 300;
        wait_drained();

        // Swap the idling; moderate timeout, whole table in play.
        send_idle_pct = 82;
        recv_idle_pct = 21;
        write_timeout(16'($urandom_range(30, 2)));
        queue_random(620, 15, 1'b0);
        wait_drained();

        // No idling; zero timeout makes any nonzero age count as timed out.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_timeout(16'd0);
        queue_random(620, 7, 1'b0);
        wait_drained();

        // Largest timeout: a few ticks leave a fresh entry healthy.
        write_timeout(16'hFFFF);
        queue_req(mk_req(shs_pkg::K_REGISTER, 9, 1'b0, 1'b0, 1'b0));
        queue_req(mk_req(shs_pkg::K_HEARTBEAT, 9, 1'b1, 1'b1, 1'b0));
        for (int k = 0; k < 3; k++)
            queue_req(mk_req(shs_pkg::K_TICK, 9, 1'b0, 1'b0, 1'b0));
        wait_drained();

        // Emergency last: SAFE latches, repeated emergencies still publish.
        send_idle_pct = 21;
        recv_idle_pct = 82;
        write_timeout(16'd3);
        queue_random(40, 15, 1'b0);
        queue_req(mk_req(shs_pkg::K_FAULT, 6, 1'b0, 1'b1, 1'b1));
        queue_random(40, 15, 1'b1);
        queue_req(mk_req(shs_pkg::K_FAULT, 9, 1'b1, 1'b0, 1'b1));
        wait_drained();
        repeat (10) @(posedge i_clk);

        $display("checked %0d reports, %0d of them published", n_checked, n_published);
        $display("states seen: INIT %0d NOMINAL %0d DEGRADED %0d SAFE %0d",
                 state_seen[shs_pkg::ST_INIT], state_seen[shs_pkg::ST_NOMINAL],
                 state_seen[shs_pkg::ST_DEGRADED], state_seen[shs_pkg::ST_SAFE]);
        if (err_count == 0 && report_q.size() == 0) begin
            $display("subsystem_health_supervisor_top test passed");
        end else begin
            $display("subsystem_health_supervisor_top test failed");
        end
        $finish;
    end

endmodule
